@@ rtl/core/dda_pkg.sv @@
// dda_pkg: shared types and constants for the DDA line rasterizer.
// Used by dda_div and dda_line_rasterizer; depends on nothing.
`default_nettype none
package dda_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/dda_line_rasterizer.sv @@
// dda_line_rasterizer: DDA line rasterizer top level with sequencer and accumulators.
// Step item: result registered at acceptance; one item per cycle unless in_stall is high.
// Load item: two passes through the shared divider, dda_div (x step, then y step), then
// the start pixel is emitted; a zero-length load registers its result at acceptance.
// Reset clears the sequencer, the output register and the accumulators; no line is active.
`default_nettype none
module dda_line_rasterizer #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  op,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y,
	output logic                       pixel_valid,
	output logic                       last_pixel
);
	localparam int ACC_W  = COORD_BITS + FRAC_BITS;
	localparam int STEP_W = ACC_W + 1;
	localparam int LEFT_W = COORD_BITS + 1;
	localparam int QW     = FRAC_BITS + 1;
	localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic [LEFT_W-1:0]    LEFT_ONE = LEFT_W'(1);

	dda_pkg::state_t    state_q, state_d;
	dda_pkg::div_stat_t div_st;

	logic                  div_go;
	logic [COORD_BITS-1:0] div_mag, div_den;
	logic [QW-1:0]         div_quo;
	logic [STEP_W-1:0]     quo_ext;

	logic [ACC_W-1:0]      acc_x_q, acc_y_q;
	logic [STEP_W-1:0]     step_x_q, step_y_q;
	logic [LEFT_W-1:0]     steps_left_q;
	logic                  line_active_q;
	logic                  neg_x_q, neg_y_q;
	logic [COORD_BITS-1:0] mag_y_q, steps_q;

	logic                  out_valid_q, pixel_valid_q, last_pixel_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;

	logic                  in_fire, out_free;
	logic [COORD_BITS-1:0] adx, ady, steps;
	logic [ACC_W-1:0]      acc_x_nx, acc_y_nx;

	assign adx   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
	assign ady   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
	assign steps = (adx > ady) ? adx : ady;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != dda_pkg::ST_IDLE) || !out_free;
	assign in_fire  = in_valid && !in_stall;

	assign acc_x_nx = acc_x_q + step_x_q[ACC_W-1:0];
	assign acc_y_nx = acc_y_q + step_y_q[ACC_W-1:0];

	assign div_mag = (state_q == dda_pkg::ST_IDLE) ? adx : mag_y_q;
	assign div_den = (state_q == dda_pkg::ST_IDLE) ? steps : steps_q;
	assign quo_ext = {{(STEP_W-QW){1'b0}}, div_quo};

	dda_div #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.mag   (div_mag),
		.den   (div_den),
		.stat  (div_st),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		unique case (state_q)
			dda_pkg::ST_IDLE: begin
				if (in_fire && op == dda_pkg::OP_LOAD && steps != '0) begin
					div_go  = 1'b1;
					state_d = dda_pkg::ST_DIV_X;
				end
			end
			dda_pkg::ST_DIV_X: begin
				if (div_st.done) begin
					div_go  = 1'b1;
					state_d = dda_pkg::ST_DIV_Y;
				end
			end
			dda_pkg::ST_DIV_Y: begin
				if (div_st.done) begin
					state_d = dda_pkg::ST_EMIT;
				end
			end
			dda_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = dda_pkg::ST_IDLE;
				end
			end
			default: state_d = dda_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			steps_left_q  <= '0;
			line_active_q <= 1'b0;
			neg_x_q       <= 1'b0;
			neg_y_q       <= 1'b0;
			mag_y_q       <= '0;
			steps_q       <= '0;
			out_valid_q   <= 1'b0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			pixel_valid_q <= 1'b0;
			last_pixel_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == dda_pkg::ST_IDLE && in_fire) begin
				out_valid_q <= 1'b1;
				if (op == dda_pkg::OP_LOAD) begin
					acc_x_q      <= {start_x, HALF};
					acc_y_q      <= {start_y, HALF};
					steps_left_q <= {1'b0, steps};
					steps_q      <= steps;
					mag_y_q      <= ady;
					neg_x_q      <= end_x < start_x;
					neg_y_q      <= end_y < start_y;
					if (steps == '0) begin
						line_active_q <= 1'b0;
						step_x_q      <= '0;
						step_y_q      <= '0;
						pixel_x_q     <= start_x;
						pixel_y_q     <= start_y;
						pixel_valid_q <= 1'b1;
						last_pixel_q  <= 1'b1;
					end else begin
						line_active_q <= 1'b1;
						out_valid_q   <= 1'b0;
					end
				end else if (line_active_q) begin
					acc_x_q       <= acc_x_nx;
					acc_y_q       <= acc_y_nx;
					steps_left_q  <= steps_left_q - LEFT_ONE;
					line_active_q <= steps_left_q != LEFT_ONE;
					pixel_x_q     <= acc_x_nx[ACC_W-1:FRAC_BITS];
					pixel_y_q     <= acc_y_nx[ACC_W-1:FRAC_BITS];
					pixel_valid_q <= 1'b1;
					last_pixel_q  <= steps_left_q == LEFT_ONE;
				end else begin
					pixel_x_q     <= '0;
					pixel_y_q     <= '0;
					pixel_valid_q <= 1'b0;
					last_pixel_q  <= 1'b0;
				end
			end
			if (state_q == dda_pkg::ST_DIV_X && div_st.done) begin
				step_x_q <= neg_x_q ? -quo_ext : quo_ext;
			end
			if (state_q == dda_pkg::ST_DIV_Y && div_st.done) begin
				step_y_q <= neg_y_q ? -quo_ext : quo_ext;
			end
			if (state_q == dda_pkg::ST_EMIT && out_free) begin
				out_valid_q   <= 1'b1;
				pixel_x_q     <= acc_x_q[ACC_W-1:FRAC_BITS];
				pixel_y_q     <= acc_y_q[ACC_W-1:FRAC_BITS];
				pixel_valid_q <= 1'b1;
				last_pixel_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_valid = pixel_valid_q;
	assign last_pixel  = last_pixel_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == dda_pkg::ST_DIV_X || state_q == dda_pkg::ST_DIV_Y))
		else $error("divider finished outside a division state");

	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> steps_left_q != '0)
		else $error("active line with no steps left");

	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_pixel) |-> pixel_valid)
		else $error("endpoint flagged on an empty result");

	a_final_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == dda_pkg::OP_STEP && line_active_q && steps_left_q == LEFT_ONE)
		|=> (out_valid && last_pixel && !line_active_q))
		else $error("final step did not flag the endpoint");

endmodule
`default_nettype wire

@@ rtl/core/dda_div.sv @@
// dda_div: shared restoring divider, one quotient bit per cycle.
// Computes (mag << FRAC_BITS) / den for mag <= den; depends on dda_pkg.
`default_nettype none
module dda_div #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic [COORD_BITS-1:0] mag,
	input  wire logic [COORD_BITS-1:0] den,
	output dda_pkg::div_stat_t         stat,
	output logic      [FRAC_BITS:0]    quo
);
	localparam int QW    = FRAC_BITS + 1;
	localparam int RW    = COORD_BITS + 1;
	localparam int CNT_W = $clog2(QW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic [QW-1:0]    quo_q;
	logic [RW-1:0]    diff;
	logic             ge;
	logic [RW-1:0]    rem_nx;

	assign diff   = rem_q - {1'b0, den_q};
	assign ge     = rem_q >= {1'b0, den_q};
	assign rem_nx = ge ? diff : rem_q;

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == CNT_LAST);
	assign quo       = {quo_q[QW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= {1'b0, mag};
			den_q  <= den;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_nx[RW-2:0], 1'b0};
			quo_q <= quo;
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
